/* design/orot_pkg.sv */
// Shared types and constants of the octave rotation generator.
// Used by the controller, the datapath and the top level.
package orot_pkg;

	localparam int MAX_OCTAVES = 16;
	localparam int OCT_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W = 49;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY = 2'd1;

	localparam logic [31:0] WAVELENGTH_RESET = 32'd67108864;
	localparam logic [31:0] LACUNARITY_RESET = 32'd33554432;
	localparam logic [31:0] HASH_C1 = 32'h7feb352d;
	localparam logic [31:0] HASH_C2 = 32'h846ca68b;
	localparam logic [31:0] SEED_STEP = 32'h9E3779B9;
	localparam logic [47:0] FREQ_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [3:0] ENTRY_LAST = 4'd8;
	localparam logic [1:0] COMP_LAST = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FDIV_GO,
		ST_FDIV_WAIT,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_CHECK,
		ST_EDIV_GO,
		ST_EDIV_WAIT,
		ST_EMIT,
		ST_SC1,
		ST_SC2,
		ST_SC3
	} state_t;

	typedef struct packed {
		logic       load;
		logic       freq_max;
		logic       div_go;
		logic       div_freq;
		logic       freq_load;
		logic       hash1;
		logic       hash2;
		logic       hash3;
		logic [1:0] comp;
		logic [3:0] entry;
		logic       entry_store;
		logic       emit;
		logic       last;
		logic       scale1;
		logic       scale2;
		logic       scale3;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic all_zero;
		logic wl_zero;
	} status_t;

endpackage

/* design/octave_rotation_generator.sv */
// Octave rotation generator: random rotations, frequencies and seeds per octave.
// The start frequency is divided out once (a zero wavelength sets it to the maximum); then per octave
// the draw rounds repeat until a component is nonzero, nine entry divisions follow, and the result is
// transferred before the frequency and seed are scaled for the next octave.
// Throughput: one request at a time; start is taken only while busy is low.
// Results are one-cycle strobes on result_valid that cannot be held off.
// Reset loads the register defaults.
module octave_rotation_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [31:0]           base_seed,
	input  logic [4:0]            octave_total,
	output logic                  result_valid,
	output logic signed [31:0]    rot_c0_r0,
	output logic signed [31:0]    rot_c1_r0,
	output logic signed [31:0]    rot_c2_r0,
	output logic signed [31:0]    rot_c0_r1,
	output logic signed [31:0]    rot_c1_r1,
	output logic signed [31:0]    rot_c2_r1,
	output logic signed [31:0]    rot_c0_r2,
	output logic signed [31:0]    rot_c1_r2,
	output logic signed [31:0]    rot_c2_r2,
	output logic [47:0]           octave_frequency,
	output logic [31:0]           octave_seed,
	output logic                  last_octave
);

	orot_pkg::cmd_t    cmd;
	orot_pkg::status_t status;

	orot_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.octave_total (octave_total),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy)
	);

	orot_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.base_seed        (base_seed),
		.cmd              (cmd),
		.status           (status),
		.result_valid     (result_valid),
		.rot_c0_r0        (rot_c0_r0),
		.rot_c1_r0        (rot_c1_r0),
		.rot_c2_r0        (rot_c2_r0),
		.rot_c0_r1        (rot_c0_r1),
		.rot_c1_r1        (rot_c1_r1),
		.rot_c2_r1        (rot_c2_r1),
		.rot_c0_r2        (rot_c0_r2),
		.rot_c1_r2        (rot_c1_r2),
		.rot_c2_r2        (rot_c2_r2),
		.octave_frequency (octave_frequency),
		.octave_seed      (octave_seed),
		.last_octave      (last_octave)
	);

endmodule

/* design/orot_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on orot_pkg for widths.
module orot_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [orot_pkg::DIV_W-1:0]    dividend,
	input  logic [31:0]                   divisor,
	output logic                          done,
	output logic [orot_pkg::DIV_W-1:0]    quotient
);

	logic [orot_pkg::DIV_W-1:0]     acc_q;
	logic [31:0]                    rem_q;
	logic [31:0]                    dvs_q;
	logic [orot_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [32:0]                    trial;
	logic                           ge;

	assign trial = {rem_q, acc_q[orot_pkg::DIV_W-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == orot_pkg::DIV_CNT_W'(orot_pkg::DIV_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			acc_q <= {acc_q[orot_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = acc_q;

endmodule

/* design/orot_ctrl.sv */
// Controller state machine of the octave rotation generator.
// Depends on orot_pkg for the state, command and status types.
module orot_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [orot_pkg::OCT_W-1:0]   octave_total,
	input  orot_pkg::status_t            status,
	output orot_pkg::cmd_t               cmd,
	output logic                         busy
);

	orot_pkg::state_t             state_q, state_d;
	logic [1:0]                   comp_q;
	logic [3:0]                   entry_q;
	logic [orot_pkg::OCT_W-1:0]   oct_q;
	logic [orot_pkg::OCT_W-1:0]   total_q;
	logic [orot_pkg::OCT_W-1:0]   total_in;
	logic                         is_last;

	assign total_in = (octave_total > orot_pkg::OCT_W'(orot_pkg::MAX_OCTAVES)) ?
		orot_pkg::OCT_W'(orot_pkg::MAX_OCTAVES) : octave_total;
	assign is_last = (oct_q + 1'b1) == total_q;
	assign busy = state_q != orot_pkg::ST_IDLE;

	always_comb begin
		state_d = state_q;
		case (state_q)
			orot_pkg::ST_IDLE: begin
				if (start)
					state_d = (total_in == '0) ? orot_pkg::ST_IDLE : orot_pkg::ST_FDIV_GO;
			end
			orot_pkg::ST_FDIV_GO:
				state_d = status.wl_zero ? orot_pkg::ST_H1 : orot_pkg::ST_FDIV_WAIT;
			orot_pkg::ST_FDIV_WAIT:
				if (status.div_done) state_d = orot_pkg::ST_H1;
			orot_pkg::ST_H1: state_d = orot_pkg::ST_H2;
			orot_pkg::ST_H2: state_d = orot_pkg::ST_H3;
			orot_pkg::ST_H3:
				state_d = (comp_q == orot_pkg::COMP_LAST) ? orot_pkg::ST_CHECK : orot_pkg::ST_H1;
			orot_pkg::ST_CHECK:
				state_d = status.all_zero ? orot_pkg::ST_H1 : orot_pkg::ST_EDIV_GO;
			orot_pkg::ST_EDIV_GO: state_d = orot_pkg::ST_EDIV_WAIT;
			orot_pkg::ST_EDIV_WAIT: begin
				if (status.div_done)
					state_d = (entry_q == orot_pkg::ENTRY_LAST) ?
						orot_pkg::ST_EMIT : orot_pkg::ST_EDIV_GO;
			end
			orot_pkg::ST_EMIT: state_d = orot_pkg::ST_SC1;
			orot_pkg::ST_SC1: state_d = orot_pkg::ST_SC2;
			orot_pkg::ST_SC2: state_d = orot_pkg::ST_SC3;
			orot_pkg::ST_SC3: state_d = is_last ? orot_pkg::ST_IDLE : orot_pkg::ST_H1;
			default: state_d = orot_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.comp = comp_q;
		cmd.entry = entry_q;
		cmd.last = is_last;
		case (state_q)
			orot_pkg::ST_IDLE: cmd.load = start;
			orot_pkg::ST_FDIV_GO: begin
				cmd.freq_max = status.wl_zero;
				cmd.div_go = !status.wl_zero;
				cmd.div_freq = 1'b1;
			end
			orot_pkg::ST_FDIV_WAIT: cmd.freq_load = status.div_done;
			orot_pkg::ST_H1: cmd.hash1 = 1'b1;
			orot_pkg::ST_H2: cmd.hash2 = 1'b1;
			orot_pkg::ST_H3: cmd.hash3 = 1'b1;
			orot_pkg::ST_EDIV_GO: cmd.div_go = 1'b1;
			orot_pkg::ST_EDIV_WAIT: cmd.entry_store = status.div_done;
			orot_pkg::ST_EMIT: cmd.emit = 1'b1;
			orot_pkg::ST_SC1: cmd.scale1 = 1'b1;
			orot_pkg::ST_SC2: cmd.scale2 = 1'b1;
			orot_pkg::ST_SC3: cmd.scale3 = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orot_pkg::ST_IDLE;
			comp_q <= '0;
			entry_q <= '0;
			oct_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				orot_pkg::ST_IDLE: begin
					if (start) begin
						total_q <= total_in;
						oct_q <= '0;
						comp_q <= '0;
					end
				end
				orot_pkg::ST_H3: comp_q <= comp_q + 1'b1;
				orot_pkg::ST_CHECK: entry_q <= '0;
				orot_pkg::ST_EDIV_WAIT: begin
					if (status.div_done) entry_q <= entry_q + 1'b1;
				end
				orot_pkg::ST_SC3: oct_q <= oct_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* design/orot_dp.sv */
// Datapath: configuration, hash, quaternion entries, frequency and seed.
// Depends on orot_pkg and orot_div.
module orot_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [orot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic [31:0]                  base_seed,
	input  orot_pkg::cmd_t               cmd,
	output orot_pkg::status_t            status,
	output logic                         result_valid,
	output logic signed [31:0]           rot_c0_r0,
	output logic signed [31:0]           rot_c1_r0,
	output logic signed [31:0]           rot_c2_r0,
	output logic signed [31:0]           rot_c0_r1,
	output logic signed [31:0]           rot_c1_r1,
	output logic signed [31:0]           rot_c2_r1,
	output logic signed [31:0]           rot_c0_r2,
	output logic signed [31:0]           rot_c1_r2,
	output logic signed [31:0]           rot_c2_r2,
	output logic [47:0]                  octave_frequency,
	output logic [31:0]                  octave_seed,
	output logic                         last_octave
);

	logic [31:0]        wl_q, lac_q;
	logic [47:0]        freq_q;
	logic [31:0]        seed_q;
	logic [31:0]        cnt_q;
	logic [31:0]        hash_s1, hash_s2;
	logic signed [3:0]  comp_q [4];
	logic [31:0]        rot_q [9];
	logic [55:0]        phi_s1, plo_s2;
	logic               valid_q;

	logic [31:0]        h0, h2, h3;
	logic [6:0]         nsum;
	logic [4:0]         nfold;
	logic [3:0]         mod15;
	logic signed [4:0]  comp_new;

	logic signed [9:0]  ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [9:0]  num;
	logic [7:0]         nrm;
	logic [7:0]         mag;
	logic               neg;

	logic               div_done;
	logic [orot_pkg::DIV_W-1:0] dvd, quo;
	logic [31:0]        dvs;
	logic [32:0]        rnd;
	logic [56:0]        fsum;
	logic [31:0]        q32;

	assign h0 = cnt_q ^ (cnt_q >> 16);
	assign h2 = hash_s1 ^ (hash_s1 >> 15);
	assign h3 = hash_s2 ^ (hash_s2 >> 16);
	assign nsum = 7'(h3[3:0]) + 7'(h3[7:4]) + 7'(h3[11:8]) + 7'(h3[15:12])
		+ 7'(h3[19:16]) + 7'(h3[23:20]) + 7'(h3[27:24]) + 7'(h3[31:28]);
	assign nfold = 5'(nsum[6:4]) + 5'(nsum[3:0]);
	assign mod15 = (nfold >= 5'd15) ? 4'(nfold - 5'd15) : nfold[3:0];
	assign comp_new = $signed({1'b0, mod15}) - 5'sd7;

	assign ww = 10'(comp_q[0] * comp_q[0]);
	assign xx = 10'(comp_q[1] * comp_q[1]);
	assign yy = 10'(comp_q[2] * comp_q[2]);
	assign zz = 10'(comp_q[3] * comp_q[3]);
	assign xy = 10'(comp_q[1] * comp_q[2]);
	assign xz = 10'(comp_q[1] * comp_q[3]);
	assign yz = 10'(comp_q[2] * comp_q[3]);
	assign wx = 10'(comp_q[0] * comp_q[1]);
	assign wy = 10'(comp_q[0] * comp_q[2]);
	assign wz = 10'(comp_q[0] * comp_q[3]);
	assign nrm = 8'(ww + xx + yy + zz);

	always_comb begin
		case (cmd.entry)
			4'd0: num = ww + xx - yy - zz;
			4'd1: num = 10'((xy - wz) <<< 1);
			4'd2: num = 10'((xz + wy) <<< 1);
			4'd3: num = 10'((xy + wz) <<< 1);
			4'd4: num = ww - xx + yy - zz;
			4'd5: num = 10'((yz - wx) <<< 1);
			4'd6: num = 10'((xz - wy) <<< 1);
			4'd7: num = 10'((yz + wx) <<< 1);
			4'd8: num = ww - xx - yy + zz;
			default: num = '0;
		endcase
	end

	assign neg = num[9];
	assign mag = neg ? 8'(-num) : num[7:0];

	always_comb begin
		if (cmd.div_freq) begin
			dvd = {1'b1, 48'd0};
			dvs = wl_q;
		end else begin
			dvd = {10'd0, mag, 31'd0} + orot_pkg::DIV_W'(nrm);
			dvs = {23'd0, nrm, 1'b0};
		end
	end

	orot_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign q32 = quo[31:0];
	assign rnd = 33'((57'(plo_s2) + 57'(1 << 23)) >> 24);
	assign fsum = {1'b0, phi_s1} + 57'(rnd);

	assign status.div_done = div_done;
	assign status.wl_zero = wl_q == '0;
	assign status.all_zero = (comp_q[0] == '0) && (comp_q[1] == '0)
		&& (comp_q[2] == '0) && (comp_q[3] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= orot_pkg::WAVELENGTH_RESET;
			lac_q <= orot_pkg::LACUNARITY_RESET;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cfg_we) begin
				case (cfg_index)
					orot_pkg::REG_WAVELENGTH: wl_q <= cfg_data;
					orot_pkg::REG_LACUNARITY: lac_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seed_q <= base_seed;
			cnt_q <= '0;
		end
		if (cmd.freq_max) freq_q <= orot_pkg::FREQ_MAX;
		if (cmd.freq_load) freq_q <= quo[48] ? orot_pkg::FREQ_MAX : quo[47:0];
		if (cmd.hash1) hash_s1 <= h0 * orot_pkg::HASH_C1;
		if (cmd.hash2) hash_s2 <= h2 * orot_pkg::HASH_C2;
		if (cmd.hash3) begin
			comp_q[cmd.comp] <= comp_new[3:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.entry_store) rot_q[cmd.entry] <= neg ? 32'(-q32) : q32;
		if (cmd.emit) begin
			rot_c0_r0 <= rot_q[0];
			rot_c1_r0 <= rot_q[1];
			rot_c2_r0 <= rot_q[2];
			rot_c0_r1 <= rot_q[3];
			rot_c1_r1 <= rot_q[4];
			rot_c2_r1 <= rot_q[5];
			rot_c0_r2 <= rot_q[6];
			rot_c1_r2 <= rot_q[7];
			rot_c2_r2 <= rot_q[8];
			octave_frequency <= freq_q;
			octave_seed <= seed_q;
			last_octave <= cmd.last;
		end
		if (cmd.scale1) phi_s1 <= 56'(freq_q[47:24]) * 56'(lac_q);
		if (cmd.scale2) plo_s2 <= 56'(freq_q[23:0]) * 56'(lac_q);
		if (cmd.scale3) begin
			freq_q <= (fsum[56:48] != '0) ? orot_pkg::FREQ_MAX : fsum[47:0];
			seed_q <= seed_q + orot_pkg::SEED_STEP;
		end
	end

	assign result_valid = valid_q;

endmodule
